### design/bfsam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsam_pkg
// Shared widths, operation codes and the adjacency store command word.
// ----------------------------------------------------------------------------
package bfsam_pkg;

    localparam int VERTEX_W = 6;
    localparam int CNT_W    = 7;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_BFS = 1'b1;

    // One access to the adjacency store: read or write of a whole row.
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [VERTEX_W-1:0] addr;
    } t_adj_cmd;

endpackage
`default_nettype wire

### design/bfsam_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsam_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfsam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### design/bfsam_adj_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsam_adj_store
// Adjacency rows in RAM; per-row valid bits make unwritten rows read as zero.
// ----------------------------------------------------------------------------
module bfsam_adj_store #(
    parameter int NODES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire bfsam_pkg::t_adj_cmd  i_cmd,
    input  wire logic [NODES-1:0]     i_wr_row,
    output logic      [NODES-1:0]     o_rd_row
);
    import bfsam_pkg::*;

    localparam int AW = $clog2(NODES);

    logic [AW-1:0]    w_addr;
    logic [NODES-1:0] w_ram_q;
    logic [NODES-1:0] r_row_vld;
    logic             r_rd_vld;

    assign w_addr = i_cmd.addr[AW-1:0];

    bfsam_ram #(
        .WIDTH (NODES),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (i_wr_row),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_addr),
        .o_rd_data (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_row_vld[w_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_row_vld[w_addr];
            end
        end
    end

    assign o_rd_row = r_rd_vld ? w_ram_q : '0;

endmodule
`default_nettype wire

### design/bfs_adjacency_matrix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix
// Undirected adjacency bit matrix with breadth-first search over it.
// ----------------------------------------------------------------------------
// Pulse start (while busy is low) with i_op = add to set the two symmetric
// bits of edge (i_vertex_u, i_vertex_v); this gives no result. Pulse start
// with i_op = search to walk from i_vertex_v: each visited vertex comes out
// as one word on o_visited_vertex, marked by a one-cycle o_strobe, start
// vertex first, then in breadth-first order; the final word of a search
// carries o_last. The receiver cannot stall, so take every strobe. Each
// expanded vertex goes through a queue RAM read, a row read from the
// adjacency RAM, a candidate load and a scan that releases its new
// neighbours. A start vertex at or above NODES gives a single result in the
// next cycle. Write vertex_count through the cfg channel only while busy is
// low. The matrix clears at reset with no sweep: each row has a valid flag.
// ----------------------------------------------------------------------------
module bfs_adjacency_matrix #(
    parameter int NODES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_op,
    input  wire logic [bfsam_pkg::VERTEX_W-1:0] i_vertex_u,
    input  wire logic [bfsam_pkg::VERTEX_W-1:0] i_vertex_v,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bfsam_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                                o_strobe,
    output logic      [bfsam_pkg::VERTEX_W-1:0] o_visited_vertex,
    output logic                                o_last
);
    import bfsam_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int PW = $clog2(NODES + 1);
    localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);
    localparam logic [NODES-1:0] ONE_ROW = {{(NODES-1){1'b0}}, 1'b1};

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ADD_RD_U = 9'b000000010,
        S_ADD_WR_U = 9'b000000100,
        S_ADD_RD_V = 9'b000001000,
        S_ADD_WR_V = 9'b000010000,
        S_DEQ      = 9'b000100000,
        S_ROW      = 9'b001000000,
        S_LOAD     = 9'b010000000,
        S_SCAN     = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_vcount;
    logic [VERTEX_W-1:0] r_u, n_u;
    logic [VERTEX_W-1:0] r_v, n_v;
    logic [NODES-1:0]    r_visited, n_visited;
    logic [NODES-1:0]    r_cand, n_cand;
    logic [PW-1:0]       r_head, n_head;
    logic [PW-1:0]       r_tail, n_tail;
    logic [VERTEX_W-1:0] r_pend, n_pend;
    logic                r_out_vld, n_out_vld;
    logic [VERTEX_W-1:0] r_out_vertex, n_out_vertex;
    logic                r_out_last, n_out_last;

    logic                w_idle;
    logic [CNT_W-1:0]    w_limit;
    logic [NODES-1:0]    w_lim_mask;
    logic [NODES-1:0]    w_low;
    logic [VERTEX_W-1:0] w_pick;
    logic                w_u_ok;
    logic                w_v_ok;

    t_adj_cmd            w_adj_cmd;
    logic [NODES-1:0]    w_adj_wr_row;
    logic [NODES-1:0]    w_adj_rd_row;

    logic                w_q_wr_en;
    logic [NW-1:0]       w_q_wr_addr;
    logic [VERTEX_W-1:0] w_q_wr_data;
    logic                w_q_rd_en;
    logic [VERTEX_W-1:0] w_q_rd_data;

    // Matrix rows: read-modify-write for add, row fetch for search.
    bfsam_adj_store #(
        .NODES (NODES)
    ) u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_adj_cmd),
        .i_wr_row (w_adj_wr_row),
        .o_rd_row (w_adj_rd_row)
    );

    // Vertex queue: written at the tail at search start and while scanning, read at the head.
    bfsam_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (NODES)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_q_wr_en),
        .i_wr_addr (w_q_wr_addr),
        .i_wr_data (w_q_wr_data),
        .i_rd_en   (w_q_rd_en),
        .i_rd_addr (r_head[NW-1:0]),
        .o_rd_data (w_q_rd_data)
    );

    assign w_idle      = (r_state == S_IDLE);
    assign busy        = !w_idle;
    assign o_cfg_ready = w_idle;

    assign w_u_ok = ({1'b0, i_vertex_u} < NODES_C);
    assign w_v_ok = ({1'b0, i_vertex_v} < NODES_C);

    // Clamp the vertex count to NODES and build the scan window.
    assign w_limit = (r_vcount > NODES_C) ? NODES_C : r_vcount;

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            w_lim_mask[i] = (CNT_W'(i) < w_limit);
        end
    end

    // Isolate the lowest pending neighbour and encode its index.
    assign w_low = r_cand & ((~r_cand) + ONE_ROW);

    always_comb begin
        w_pick = '0;
        for (int i = 0; i < NODES; i++) begin
            if (w_low[i]) begin
                w_pick = w_pick | VERTEX_W'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_u          = r_u;
        n_v          = r_v;
        n_visited    = r_visited;
        n_cand       = r_cand;
        n_head       = r_head;
        n_tail       = r_tail;
        n_pend       = r_pend;
        n_out_vld    = 1'b0;
        n_out_vertex = r_out_vertex;
        n_out_last   = r_out_last;

        w_adj_cmd    = '0;
        w_adj_wr_row = w_adj_rd_row | (ONE_ROW << r_v[NW-1:0]);
        w_q_wr_en    = 1'b0;
        w_q_wr_addr  = r_tail[NW-1:0];
        w_q_wr_data  = w_pick;
        w_q_rd_en    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_u = i_vertex_u;
                    n_v = i_vertex_v;
                    if (i_op == OP_ADD) begin
                        // Drop edges with an end outside the matrix.
                        if (w_u_ok && w_v_ok) begin
                            n_state = S_ADD_RD_U;
                        end
                    end else if (!w_v_ok) begin
                        n_out_vld    = 1'b1;
                        n_out_vertex = i_vertex_v;
                        n_out_last   = 1'b1;
                    end else begin
                        n_visited   = ONE_ROW << i_vertex_v[NW-1:0];
                        w_q_wr_en   = 1'b1;
                        w_q_wr_addr = '0;
                        w_q_wr_data = i_vertex_v;
                        n_head      = '0;
                        n_tail      = PW'(1);
                        n_pend      = i_vertex_v;
                        n_state     = S_DEQ;
                    end
                end
            end
            S_ADD_RD_U: begin
                w_adj_cmd.rd_en = 1'b1;
                w_adj_cmd.addr  = r_u;
                n_state         = S_ADD_WR_U;
            end
            S_ADD_WR_U: begin
                w_adj_cmd.wr_en = 1'b1;
                w_adj_cmd.addr  = r_u;
                n_state         = S_ADD_RD_V;
            end
            S_ADD_RD_V: begin
                w_adj_cmd.rd_en = 1'b1;
                w_adj_cmd.addr  = r_v;
                n_state         = S_ADD_WR_V;
            end
            S_ADD_WR_V: begin
                w_adj_cmd.wr_en = 1'b1;
                w_adj_cmd.addr  = r_v;
                w_adj_wr_row    = w_adj_rd_row | (ONE_ROW << r_u[NW-1:0]);
                n_state         = S_IDLE;
            end
            S_DEQ: begin
                if (r_head == r_tail) begin
                    // Queue drained: the held vertex is the final word.
                    n_out_vld    = 1'b1;
                    n_out_vertex = r_pend;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    w_q_rd_en = 1'b1;
                    n_head    = r_head + PW'(1);
                    n_state   = S_ROW;
                end
            end
            S_ROW: begin
                w_adj_cmd.rd_en = 1'b1;
                w_adj_cmd.addr  = w_q_rd_data;
                n_state         = S_LOAD;
            end
            S_LOAD: begin
                n_cand  = w_adj_rd_row & ~r_visited & w_lim_mask;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cand == '0) begin
                    n_state = S_DEQ;
                end else begin
                    // Release the held vertex, hold the new one until the
                    // next is found or the search ends.
                    n_out_vld    = 1'b1;
                    n_out_vertex = r_pend;
                    n_out_last   = 1'b0;
                    n_pend       = w_pick;
                    n_visited    = r_visited | w_low;
                    n_cand       = r_cand & ~w_low;
                    w_q_wr_en    = 1'b1;
                    n_tail       = r_tail + PW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vcount  <= CNT_W'(64);
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vcount <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_u          <= n_u;
        r_v          <= n_v;
        r_visited    <= n_visited;
        r_cand       <= n_cand;
        r_head       <= n_head;
        r_tail       <= n_tail;
        r_pend       <= n_pend;
        r_out_vertex <= n_out_vertex;
        r_out_last   <= n_out_last;
    end

    assign o_strobe         = r_out_vld;
    assign o_visited_vertex = r_out_vertex;
    assign o_last           = r_out_last;

endmodule
`default_nettype wire

### design/bfsam_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfsam_chk
// Port-level checks on the search block, attached by bind.
// ----------------------------------------------------------------------------
module bfsam_chk #(
    parameter int NODES = 64
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           i_op,
    input wire logic [bfsam_pkg::VERTEX_W-1:0] i_vertex_v,
    input wire logic                           o_strobe,
    input wire logic [bfsam_pkg::VERTEX_W-1:0] o_visited_vertex,
    input wire logic                           o_last
);
    import bfsam_pkg::*;

    localparam logic [CNT_W-1:0] NODES_C = CNT_W'(NODES);

    // An add never yields a word.
    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == OP_ADD |=> !o_strobe)
        else $error("word after add");

    // Start outside the matrix: single final word with the start vertex.
    a_far_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == OP_BFS && {1'b0, i_vertex_v} >= NODES_C
        |=> o_strobe && o_last && o_visited_vertex == $past(i_vertex_v))
        else $error("bad result for out-of-range start");

    // In-range start: the walk runs, nothing comes out right away.
    a_near_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == OP_BFS && {1'b0, i_vertex_v} < NODES_C
        |=> busy && !o_strobe)
        else $error("search did not start");

    // The final word comes out as the block goes idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final word while busy");

    // Any other word comes out mid-search.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final word while idle");

endmodule

bind bfs_adjacency_matrix bfsam_chk #(.NODES(NODES)) u_bfsam_chk (.*);
`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adjacency matrix breadth-first search block.
// A directed table covers the reset state, self-loops, duplicate edges and
// the vertex count extremes. Random edge and search words follow, under
// several vertex counts and sender idle rates. A behavioral walk of the
// same graph predicts the words of each search not known up front. Each
// strobed word is checked in order against the owed words.
// ----------------------------------------------------------------------------
module tb_top;
    import bfsam_pkg::*;

    localparam int NV = 64;

    typedef struct packed {
        logic [VERTEX_W-1:0] vtx;
        logic                is_last;
    } visit_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e           kind;
        logic                op;
        logic [VERTEX_W-1:0] u;
        logic [VERTEX_W-1:0] v;
        logic [CNT_W-1:0]    cnt;
        logic                typed;  // single word {v, last} known up front
    } row_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_op;
    logic [VERTEX_W-1:0] i_vertex_u;
    logic [VERTEX_W-1:0] i_vertex_v;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data;
    logic                o_strobe;
    logic [VERTEX_W-1:0] o_visited_vertex;
    logic                o_last;

    // Shadow copy of the graph and the vertex count register.
    logic [NV-1:0]    graph_rows [NV];
    logic [CNT_W-1:0] shadow_count;

    // Visit words still owed by the block, oldest first.
    visit_t pending_visits [$];
    int     errors;

    row_t plan [23];

    bfs_adjacency_matrix #(.NODES(NV)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_vertex_u      (i_vertex_u),
        .i_vertex_v      (i_vertex_v),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_visited_vertex(o_visited_vertex),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    // Walk the shadow graph from root and queue the visit words in order.
    function automatic void predict_walk(input logic [VERTEX_W-1:0] root);
        logic [NV-1:0]       seen;
        logic [VERTEX_W-1:0] fifo [NV];
        logic [NV-1:0]       row;
        visit_t              found [$];
        visit_t              w;
        int                  head;
        int                  tail;
        int                  lim;
        int                  k;
        seen = '0;
        head = 0;
        tail = 0;
        lim  = (shadow_count > NV) ? NV : int'(shadow_count);
        w.vtx = root;
        w.is_last = 1'b0;
        found.push_back(w);
        seen[root] = 1'b1;
        fifo[tail] = root;
        tail++;
        while (head != tail && head < NV) begin
            row = graph_rows[fifo[head]];
            head++;
            // Scan neighbors in ascending order below the vertex count.
            for (k = 0; k < lim; k++) begin
                if (row[k] && !seen[k]) begin
                    seen[k] = 1'b1;
                    w.vtx = VERTEX_W'(k);
                    if (found.size() < NV) found.push_back(w);
                    if (tail < NV) begin
                        fifo[tail] = VERTEX_W'(k);
                        tail++;
                    end
                end
            end
        end
        for (k = 0; k < found.size(); k++) begin
            w = found[k];
            w.is_last = (k == found.size() - 1);
            pending_visits.push_back(w);
        end
    endfunction

    // Offer one command word; idle the sender first with the given odds.
    // On acceptance, update the shadow graph or queue the expected visits.
    task automatic send_word(input logic op, input logic [VERTEX_W-1:0] u,
                             input logic [VERTEX_W-1:0] v, input bit typed,
                             input int idle_pct);
        visit_t w;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_op       <= op;
        i_vertex_u <= u;
        i_vertex_v <= v;
        do @(posedge i_clk); while (busy);
        if (op == OP_ADD) begin
            graph_rows[u][v] = 1'b1;
            graph_rows[v][u] = 1'b1;
        end else if (typed) begin
            w.vtx = v;
            w.is_last = 1'b1;
            pending_visits.push_back(w);
        end else begin
            predict_walk(v);
        end
    endtask

    // Drop start, wait for every owed word and for busy to fall, then give
    // a trailing edge add time to settle before touching the register.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_visits.size() != 0 || busy);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly edges, half of the words among a small cluster so
    // searches reach far, the rest spread over the whole index range.
    task automatic run_phase(input logic [CNT_W-1:0] value, input int idle_pct,
                             input int words);
        logic                op;
        logic [VERTEX_W-1:0] u;
        logic [VERTEX_W-1:0] v;
        int                  span;
        write_count(value);
        repeat (words) begin
            op   = ($urandom_range(0, 99) < 65) ? OP_ADD : OP_BFS;
            span = $urandom_range(0, 1) ? 15 : 63;
            u    = VERTEX_W'($urandom_range(0, span));
            v    = VERTEX_W'($urandom_range(0, span));
            send_word(op, u, v, 1'b0, idle_pct);
        end
    endtask

    // Check each strobed word against the oldest owed visit.
    always @(posedge i_clk) begin
        visit_t w;
        if (i_rst_n && o_strobe) begin
            if (pending_visits.size() == 0) begin
                $error("unexpected visit word: vertex %0d last %0b",
                       o_visited_vertex, o_last);
                errors++;
            end else begin
                w = pending_visits.pop_front();
                if (o_visited_vertex !== w.vtx) begin
                    $error("visited_vertex: expected %0d, got %0d",
                           w.vtx, o_visited_vertex);
                    errors++;
                end
                if (o_last !== w.is_last) begin
                    $error("last: expected %0b, got %0b", w.is_last, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int i;
        errors = 0;
        shadow_count = CNT_W'(NV);
        for (i = 0; i < NV; i++) graph_rows[i] = '0;

        plan = '{
            // Empty graph after reset: each search yields its root alone.
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd0,  7'd0,   1'b1},
            '{ROW_ITEM, OP_BFS, 6'd63, 6'd63, 7'd0,   1'b1},
            // Corner edge, its duplicate in reverse, and a self-loop.
            '{ROW_ITEM, OP_ADD, 6'd0,  6'd63, 7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd63, 6'd0,  7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd5,  6'd5,  7'd0,   1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd5,  7'd0,   1'b1},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd0,  7'd0,   1'b0},
            // Small tree hanging off vertex 0.
            '{ROW_ITEM, OP_ADD, 6'd0,  6'd1,  7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd1,  6'd2,  7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd2,  6'd3,  7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd0,  6'd4,  7'd0,   1'b0},
            '{ROW_ITEM, OP_ADD, 6'd4,  6'd62, 7'd0,   1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd0,  7'd0,   1'b0},
            // Count zero: nothing is followed.
            '{ROW_CFG,  OP_ADD, 6'd0,  6'd0,  7'd0,   1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd0,  7'd0,   1'b1},
            // Count at the top of its range, clamped to the node count.
            '{ROW_CFG,  OP_ADD, 6'd0,  6'd0,  7'd127, 1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd63, 7'd0,   1'b0},
            // Count one: root outside the count still has its row scanned.
            '{ROW_CFG,  OP_ADD, 6'd0,  6'd0,  7'd1,   1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd0,  7'd0,   1'b1},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd63, 7'd0,   1'b0},
            // Just above the node count.
            '{ROW_CFG,  OP_ADD, 6'd0,  6'd0,  7'd65,  1'b0},
            '{ROW_ITEM, OP_BFS, 6'd0,  6'd2,  7'd0,   1'b0},
            '{ROW_CFG,  OP_ADD, 6'd0,  6'd0,  7'd64,  1'b0}
        };

        // Hold every input at a known value with reset asserted, then release reset.
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_ADD;
        i_vertex_u  <= '0;
        i_vertex_v  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_count(plan[i].cnt);
            else
                send_word(plan[i].op, plan[i].u, plan[i].v, plan[i].typed, 13);
        end

        // Sender idles 13 in 100, then 46 in 100, then never.
        run_phase(CNT_W'($urandom_range(2, 63)), 13, 55);
        run_phase(7'd64, 13, 55);
        run_phase(7'd16, 46, 55);
        run_phase(7'd127, 46, 55);
        run_phase(CNT_W'($urandom_range(0, 127)), 0, 55);
        run_phase(7'd64, 0, 55);

        // Drain owed words and give stray strobes a chance to show.
        start <= 1'b0;
        do @(posedge i_clk); while (pending_visits.size() != 0);
        repeat (400) @(posedge i_clk);

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

### sim.f
design/bfsam_pkg.sv
design/bfsam_ram.sv
design/bfsam_adj_store.sv
design/bfs_adjacency_matrix.sv
design/bfsam_chk.sv
tb/tb_top.sv
